>>> design/pbf_pkg.sv
// Shared types and constants for the pipe byte FIFO engine.
// Depends on nothing; every other design file imports it.
package pbf_pkg;

  // Field widths fixed by the item format.
  localparam int ACTION_W   = 3;
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 17;
  localparam int OFF_W      = 16;
  localparam int POLL_REQ_W = 3;
  localparam int STATUS_W   = 3;
  localparam int READY_W    = 5;
  localparam int FILL_W     = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_NB  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_NB = 1'd1;

  // Default sizes.
  localparam int DEPTH_DEF  = 65536;
  localparam int ATOMIC_DEF = 4096;

  typedef enum logic [ACTION_W-1:0] {
    ACT_OPEN     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_READ     = 3'd2,
    ACT_PEEK     = 3'd3,
    ACT_CLOSE_RD = 3'd4,
    ACT_CLOSE_WR = 3'd5,
    ACT_POLL_RD  = 3'd6,
    ACT_POLL_WR  = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_AGAIN   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_EOF     = 3'd3,
    ST_BROKEN  = 3'd4,
    ST_ENDS    = 3'd5,
    ST_INVALID = 3'd6
  } status_e;

  // Poll readiness bit positions.
  localparam int RDY_READABLE = 0;
  localparam int RDY_WRITABLE = 1;
  localparam int RDY_HANGUP   = 2;
  localparam int RDY_ERROR    = 3;
  localparam int RDY_PEER_HUP = 4;

  // Poll request bit positions.
  localparam int REQ_READABLE = 0;
  localparam int REQ_WRITABLE = 1;
  localparam int REQ_PEER_HUP = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // carry out the captured item and register its result
  } ctl_cmd_t;

endpackage

>>> design/pbf_ctrl.sv
// Controller for the pipe byte FIFO engine: sequences capture and execution.
// Depends on pbf_pkg.
module pbf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output pbf_pkg::ctl_cmd_t cmd_o
);
  import pbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // An item is taken whenever the engine is not executing, also in the
  // cycle that shows the previous result.
  assign cmd_o.load = start && !busy_q;
  assign cmd_o.exec = busy_q;
  assign busy       = busy_q;
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE, S_DONE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> design/pbf_dpath.sv
// Datapath for the pipe byte FIFO engine: byte ring memory, pointers, count,
// end flags, configuration bits and the per-item decision logic.
// Depends on pbf_pkg.
module pbf_dpath #(
  parameter int DEPTH        = pbf_pkg::DEPTH_DEF,
  parameter int ATOMIC_LIMIT = pbf_pkg::ATOMIC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pbf_pkg::ctl_cmd_t               cmd_i,
  input  logic                            cfg_we_i,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [pbf_pkg::ACTION_W-1:0]    action_i,
  input  logic [pbf_pkg::DATA_W-1:0]      write_data_i,
  input  logic [pbf_pkg::LEN_W-1:0]       call_length_i,
  input  logic                            first_of_call_i,
  input  logic [pbf_pkg::OFF_W-1:0]       peek_offset_i,
  input  logic [pbf_pkg::POLL_REQ_W-1:0]  poll_request_i,
  output logic [pbf_pkg::STATUS_W-1:0]    status_o,
  output logic [pbf_pkg::DATA_W-1:0]      read_data_o,
  output logic [pbf_pkg::READY_W-1:0]     poll_ready_o,
  output logic [pbf_pkg::FILL_W-1:0]      fill_level_o
);
  import pbf_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = OFF_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(DEPTH);
  localparam logic [LEN_W-1:0]  ATOMIC_L  = LEN_W'(ATOMIC_LIMIT);
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(DEPTH);

  // Captured item.
  action_e                 act_q;
  logic [DATA_W-1:0]       wdata_q;
  logic [LEN_W-1:0]        len_q;
  logic                    first_q;
  logic [OFF_W-1:0]        off_q;
  logic [POLL_REQ_W-1:0]   req_q;

  // Pipe state.
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wclosed_q, wclosed_d;
  logic             rclosed_q, rclosed_d;
  logic             rd_nb_q;
  logic             wr_nb_q;

  // Result registers.
  status_e            status_q, status_d;
  logic [READY_W-1:0] ready_q, ready_d;
  logic               rd_ok_q, rd_ok_d;
  logic [DATA_W-1:0]  rdata_q;

  logic [DATA_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [PTR_W-1:0]  rd_addr;
  logic [SUM_W-1:0]  peek_sum;
  logic [SUM_W-1:0]  peek_wrap;
  logic [FILL_W-1:0] cnt_f;
  logic [FILL_W-1:0] space;
  logic              empty;
  logic              full;
  logic              atomic_fail;

  assign cnt_f = FILL_W'(cnt_q);
  assign space = DEPTH_F - cnt_f;
  assign empty = (cnt_q == '0);
  assign full  = (space == '0);

  // A small call must fit whole; a large one only needs some room.
  assign atomic_fail = (len_q <= ATOMIC_L) ? (space < FILL_W'(len_q)) : full;

  // Peek address wraps once at most for a successful peek, whose offset stays below the count.
  assign peek_sum  = SUM_W'(rd_ptr_q) + SUM_W'(off_q);
  assign peek_wrap = (peek_sum >= DEPTH_S) ? (peek_sum - DEPTH_S) : peek_sum;
  assign rd_addr   = (act_q == ACT_PEEK) ? peek_wrap[PTR_W-1:0] : rd_ptr_q;

  always_comb begin
    status_d  = ST_OK;
    ready_d   = '0;
    rd_ok_d   = 1'b0;
    mem_we    = 1'b0;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    wclosed_d = wclosed_q;
    rclosed_d = rclosed_q;
    case (act_q)
      ACT_OPEN: begin
        rd_ptr_d  = '0;
        wr_ptr_d  = '0;
        cnt_d     = '0;
        wclosed_d = 1'b0;
        rclosed_d = 1'b0;
      end
      ACT_WRITE: begin
        if (len_q == '0 || wclosed_q) begin
          status_d = ST_INVALID;
        end else if (rclosed_q) begin
          status_d = ST_BROKEN;
        end else if (first_q && wr_nb_q && atomic_fail) begin
          status_d = ST_AGAIN;
        end else if (full) begin
          status_d = first_q ? ST_BLOCKED : ST_ENDS;
        end else begin
          mem_we   = 1'b1;
          wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      ACT_READ: begin
        if (len_q == '0 || rclosed_q) begin
          status_d = ST_INVALID;
        end else if (empty) begin
          if (!first_q) begin
            status_d = ST_ENDS;
          end else if (wclosed_q) begin
            status_d = ST_EOF;
          end else begin
            status_d = rd_nb_q ? ST_AGAIN : ST_BLOCKED;
          end
        end else begin
          rd_ok_d  = 1'b1;
          rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      ACT_PEEK: begin
        if (len_q == '0 || rclosed_q) begin
          status_d = ST_INVALID;
        end else if (FILL_W'(off_q) >= cnt_f) begin
          status_d = ST_ENDS;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      ACT_CLOSE_RD: begin
        rclosed_d = 1'b1;
      end
      ACT_CLOSE_WR: begin
        wclosed_d = 1'b1;
      end
      ACT_POLL_RD: begin
        ready_d[RDY_READABLE] = req_q[REQ_READABLE] && (!empty || wclosed_q);
        ready_d[RDY_HANGUP]   = wclosed_q;
        ready_d[RDY_PEER_HUP] = wclosed_q && req_q[REQ_PEER_HUP];
      end
      ACT_POLL_WR: begin
        ready_d[RDY_WRITABLE] = !full && !rclosed_q && req_q[REQ_WRITABLE];
        ready_d[RDY_HANGUP]   = rclosed_q;
        ready_d[RDY_ERROR]    = rclosed_q;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Captured item and result registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      wdata_q <= write_data_i;
      len_q   <= call_length_i;
      first_q <= first_of_call_i;
      off_q   <= peek_offset_i;
      req_q   <= poll_request_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      ready_q  <= ready_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[wr_ptr_q] <= wdata_q;
    end
    if (cmd_i.exec) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      wclosed_q <= 1'b0;
      rclosed_q <= 1'b0;
      rd_nb_q   <= 1'b0;
      wr_nb_q   <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        rd_ptr_q  <= rd_ptr_d;
        wr_ptr_q  <= wr_ptr_d;
        cnt_q     <= cnt_d;
        wclosed_q <= wclosed_d;
        rclosed_q <= rclosed_d;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_READ_NB) begin
          rd_nb_q <= cfg_wdata_i[0];
        end
        if (cfg_idx_i == CFG_WRITE_NB) begin
          wr_nb_q <= cfg_wdata_i[0];
        end
      end
    end
  end

  assign status_o     = status_q;
  assign read_data_o  = rd_ok_q ? rdata_q : '0;
  assign poll_ready_o = ready_q;
  assign fill_level_o = cnt_f;

endmodule

>>> design/pipe_byte_fifo_engine.sv
// Top level of the pipe byte FIFO engine: a byte ring with pipe semantics.
// Depends on pbf_pkg, pbf_ctrl and pbf_dpath.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------------
//   item in  | start, busy        | action_i, write_data_i, call_length_i,
//            |                    | first_of_call_i, peek_offset_i,
//            |                    | poll_request_i
//   result   | done_o             | status_o, read_data_o, poll_ready_o,
//            |                    | fill_level_o
//   config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// An item is transferred at a clock edge with start high and busy low. It is
// carried out in the following cycle (busy high), and its result is shown
// with done_o for exactly the cycle after that. This sequence is set by the
// registered read port of the byte memory: the read or peek address depends
// on the captured item, and the byte is registered as the item is carried
// out. A new item may be transferred in the cycle that shows a result.
// The result transfer cannot be held off by the receiver.
// Reset clears the pointers, count, end flags and both configuration bits;
// the memory contents stay undefined until written and no clearing pass runs.
module pipe_byte_fifo_engine #(
  parameter int DEPTH        = pbf_pkg::DEPTH_DEF,
  parameter int ATOMIC_LIMIT = pbf_pkg::ATOMIC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_we_i,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [pbf_pkg::ACTION_W-1:0]    action_i,
  input  logic [pbf_pkg::DATA_W-1:0]      write_data_i,
  input  logic [pbf_pkg::LEN_W-1:0]       call_length_i,
  input  logic                            first_of_call_i,
  input  logic [pbf_pkg::OFF_W-1:0]       peek_offset_i,
  input  logic [pbf_pkg::POLL_REQ_W-1:0]  poll_request_i,
  output logic                            done_o,
  output logic [pbf_pkg::STATUS_W-1:0]    status_o,
  output logic [pbf_pkg::DATA_W-1:0]      read_data_o,
  output logic [pbf_pkg::READY_W-1:0]     poll_ready_o,
  output logic [pbf_pkg::FILL_W-1:0]      fill_level_o
);
  import pbf_pkg::*;

  // The controller only sequences; every decision about the pipe is made in
  // the datapath from the captured item and the current pipe state.
  ctl_cmd_t cmd;

  pbf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // The datapath holds the byte memory, the ring pointers, the fill count,
  // the end flags and the two nonblocking configuration bits.
  pbf_dpath #(
    .DEPTH        (DEPTH),
    .ATOMIC_LIMIT (ATOMIC_LIMIT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .write_data_i    (write_data_i),
    .call_length_i   (call_length_i),
    .first_of_call_i (first_of_call_i),
    .peek_offset_i   (peek_offset_i),
    .poll_request_i  (poll_request_i),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .poll_ready_o    (poll_ready_o),
    .fill_level_o    (fill_level_o)
  );

endmodule

>>> design/pbf_checker.sv
// Port-level checks for the pipe byte FIFO engine, bound to the top level.
// Depends on pbf_pkg and pipe_byte_fifo_engine.
module pbf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [pbf_pkg::STATUS_W-1:0]    status_o,
  input logic [pbf_pkg::DATA_W-1:0]      read_data_o,
  input logic [pbf_pkg::READY_W-1:0]     poll_ready_o
);
  import pbf_pkg::*;

  // A transferred item is executing in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item transfer not followed by execution");

  // Execution always ends in a result in the next cycle, with busy low.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("execution did not end in a result");

  // A result only follows execution.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a preceding execution cycle");

  // A returned byte or readiness bit only comes with a successful status.
  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (read_data_o != '0 || poll_ready_o != '0) |-> status_o == ST_OK)
    else $error("data or readiness reported with a failing status");

endmodule

bind pipe_byte_fifo_engine pbf_checker u_pbf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .read_data_o  (read_data_o),
  .poll_ready_o (poll_ready_o)
);
